[hw/rtl/sawpc_pkg.sv]
// Sawtooth pulse checker package: shared widths, the default pulse cap, register indexes and
// amplitude status codes. No dependencies.
`default_nettype none

package sawpc_pkg;

	// Payload and register widths
	localparam int SAMPLE_W = 16;
	localparam int COUNT_W  = 16;
	localparam int TOL_W    = 15;
	localparam int CFG_W    = 16;
	localparam int CFG_IDX_W = 2;

	// Default cap on the sample count of one pulse
	localparam longint unsigned MAX_PULSE_SAMPLES_DEF = 64'd65535;

	// Configuration register indexes
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_AMP_LOW_TARGET  = 2'd0,
		REG_AMP_HIGH_TARGET = 2'd1,
		REG_TOLERANCE       = 2'd2,
		REG_EXPECTED_WIDTH  = 2'd3
	} cfg_reg_t;

	// Amplitude status codes
	localparam logic [1:0] AMP_NORMAL   = 2'd0;
	localparam logic [1:0] AMP_MIN_OUT  = 2'd1;
	localparam logic [1:0] AMP_MAX_OUT  = 2'd2;
	localparam logic [1:0] AMP_BOTH_OUT = 2'd3;

endpackage

`default_nettype wire

[hw/rtl/sawtooth_pulse_checker.sv]
// Sawtooth pulse checker: an input transfer reaches its verdict on the output
// through the input register, then the result register.
// Throughput is one sample per cycle; a sample only waits when it carries the
// last-sample flag and the result register holds an untaken verdict.
// Reset clears pulse state, configuration registers and all valid flags.
// Depends on sawpc_pkg.
`default_nettype none

module sawtooth_pulse_checker #(
	parameter longint unsigned MAX_PULSE_SAMPLES = sawpc_pkg::MAX_PULSE_SAMPLES_DEF
) (
	input  wire logic                                  clk,
	input  wire logic                                  arst_n,
	// configuration write port
	input  wire logic                                  cfg_write_en,
	input  wire logic [sawpc_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  wire logic [sawpc_pkg::CFG_W-1:0]           cfg_data,
	// sample input channel
	input  wire logic                                  in_valid,
	output logic                                       in_stall,
	input  wire logic signed [sawpc_pkg::SAMPLE_W-1:0] sample,
	input  wire logic                                  last_sample,
	// verdict output channel
	output logic                                       out_valid,
	input  wire logic                                  out_stall,
	output logic                                       form_ok,
	output logic [sawpc_pkg::COUNT_W-1:0]              bad_index,
	output logic [1:0]                                 amp_status,
	output logic signed [sawpc_pkg::SAMPLE_W-1:0]      measured_min,
	output logic signed [sawpc_pkg::SAMPLE_W-1:0]      measured_max,
	output logic                                       width_ok,
	output logic [sawpc_pkg::COUNT_W-1:0]              measured_width,
	output logic                                       all_ok
);

	localparam int SW = sawpc_pkg::SAMPLE_W;
	localparam int CW = sawpc_pkg::COUNT_W;
	localparam int EW = SW + 2;
	localparam longint unsigned COUNT_MAX = (64'd1 << CW) - 64'd1;
	localparam logic [CW-1:0] COUNT_CAP =
		(MAX_PULSE_SAMPLES > COUNT_MAX) ? CW'(COUNT_MAX) :
		(MAX_PULSE_SAMPLES < 64'd1)     ? CW'(1) : CW'(MAX_PULSE_SAMPLES);

	// configuration registers
	logic signed [SW-1:0]            amp_low_target_q;
	logic signed [SW-1:0]            amp_high_target_q;
	logic [sawpc_pkg::TOL_W-1:0]     tolerance_q;
	logic [CW-1:0]                   expected_width_q;

	// input stage
	logic                            valid_s1;
	logic signed [SW-1:0]            sample_s1;
	logic                            last_s1;

	// pulse state
	logic signed [SW-1:0]            running_min_q;
	logic signed [SW-1:0]            running_max_q;
	logic signed [SW-1:0]            previous_sample_q;
	logic [CW-1:0]                   sample_count_q;
	logic                            rising_ok_q;
	logic [CW-1:0]                   first_bad_index_q;

	// next pulse state
	logic                            first_smp;
	logic                            fall;
	logic signed [SW-1:0]            nxt_min;
	logic signed [SW-1:0]            nxt_max;
	logic [CW-1:0]                   nxt_count;
	logic                            nxt_rising;
	logic [CW-1:0]                   nxt_bad;

	// verdict
	logic signed [EW-1:0]            tol_ext;
	logic signed [EW-1:0]            low_lo;
	logic signed [EW-1:0]            low_hi;
	logic signed [EW-1:0]            high_lo;
	logic signed [EW-1:0]            high_hi;
	logic                            min_out;
	logic                            max_out;
	logic                            wid_ok;

	// handshake
	logic                            out_free;
	logic                            s1_move;
	logic                            in_xfer;

	// Let the input stage drain unless a verdict must wait for the result register
	assign out_free = !out_valid || !out_stall;
	assign s1_move  = valid_s1 && (!last_s1 || out_free);
	assign in_stall = valid_s1 && !s1_move;
	assign in_xfer  = in_valid && !in_stall;

	// Write configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			amp_low_target_q  <= '0;
			amp_high_target_q <= '0;
			tolerance_q       <= '0;
			expected_width_q  <= '0;
		end else if (cfg_write_en) begin
			case (sawpc_pkg::cfg_reg_t'(cfg_index))
				sawpc_pkg::REG_AMP_LOW_TARGET:  amp_low_target_q  <= cfg_data;
				sawpc_pkg::REG_AMP_HIGH_TARGET: amp_high_target_q <= cfg_data;
				sawpc_pkg::REG_TOLERANCE:       tolerance_q <= cfg_data[sawpc_pkg::TOL_W-1:0];
				sawpc_pkg::REG_EXPECTED_WIDTH:  expected_width_q  <= cfg_data;
				default: ;
			endcase
		end
	end

	// Capture the input transfer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_xfer) begin
			valid_s1 <= 1'b1;
		end else if (s1_move) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_xfer) begin
			sample_s1 <= sample;
			last_s1   <= last_sample;
		end
	end

	// Advance min, max, count and the rising check with the staged sample
	always_comb begin
		first_smp  = (sample_count_q == '0);
		fall       = !first_smp && rising_ok_q && (previous_sample_q >= sample_s1);
		nxt_min    = (first_smp || sample_s1 < running_min_q) ? sample_s1 : running_min_q;
		nxt_max    = (first_smp || sample_s1 > running_max_q) ? sample_s1 : running_max_q;
		nxt_count  = (sample_count_q < COUNT_CAP) ? sample_count_q + CW'(1) : sample_count_q;
		nxt_rising = rising_ok_q && !fall;
		nxt_bad    = fall ? sample_count_q - CW'(1) : first_bad_index_q;
	end

	// Classify the amplitude against both tolerance windows, edges inclusive
	always_comb begin
		tol_ext = EW'($signed({1'b0, tolerance_q}));
		low_lo  = EW'(amp_low_target_q) - tol_ext;
		low_hi  = EW'(amp_low_target_q) + tol_ext;
		high_lo = EW'(amp_high_target_q) - tol_ext;
		high_hi = EW'(amp_high_target_q) + tol_ext;
		min_out = (EW'(nxt_min) < low_lo) || (EW'(nxt_min) > low_hi);
		max_out = (EW'(nxt_max) < high_lo) || (EW'(nxt_max) > high_hi);
		wid_ok  = (nxt_count == expected_width_q);
	end

	// Hold pulse state; clear it after a verdict
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			running_min_q     <= '0;
			running_max_q     <= '0;
			previous_sample_q <= '0;
			sample_count_q    <= '0;
			rising_ok_q       <= 1'b1;
			first_bad_index_q <= '0;
		end else if (s1_move) begin
			if (last_s1) begin
				running_min_q     <= '0;
				running_max_q     <= '0;
				previous_sample_q <= '0;
				sample_count_q    <= '0;
				rising_ok_q       <= 1'b1;
				first_bad_index_q <= '0;
			end else begin
				running_min_q     <= nxt_min;
				running_max_q     <= nxt_max;
				previous_sample_q <= sample_s1;
				sample_count_q    <= nxt_count;
				rising_ok_q       <= nxt_rising;
				first_bad_index_q <= nxt_bad;
			end
		end
	end

	// Result register: load a verdict, drop it once transferred
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (s1_move && last_s1) begin
			out_valid <= 1'b1;
		end else if (!out_stall) begin
			out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_move && last_s1) begin
			form_ok        <= nxt_rising;
			bad_index      <= nxt_rising ? '0 : nxt_bad;
			amp_status     <= {max_out, min_out};
			measured_min   <= nxt_min;
			measured_max   <= nxt_max;
			width_ok       <= wid_ok;
			measured_width <= nxt_count;
			all_ok         <= nxt_rising && wid_ok && !min_out && !max_out;
		end
	end

`ifndef ASSERT_OFF
	// A verdict that cannot enter the full result register must back-pressure the input
	a_verdict_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && last_s1 && out_valid && out_stall) |-> in_stall)
		else $error("verdict overwrote a stalled result");

	// A passing form test reports index zero
	a_bad_index_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && form_ok) |-> (bad_index == '0))
		else $error("bad_index set with form_ok");

	// Overall pass agrees with the three tests
	a_all_ok: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (all_ok == (form_ok && width_ok &&
			amp_status == sawpc_pkg::AMP_NORMAL)))
		else $error("all_ok inconsistent");

	// Count never passes its cap
	a_count_cap: assert property (@(posedge clk) disable iff (!arst_n)
		sample_count_q <= COUNT_CAP)
		else $error("sample count beyond cap");

	// Reported minimum never exceeds reported maximum
	a_min_max: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (measured_min <= measured_max))
		else $error("measured_min above measured_max");
`endif

endmodule

`default_nettype wire

[verif/tb.sv]
`timescale 1ns / 1ps
// Testbench for sawtooth_pulse_checker: holds the verdict scoreboard class,
// the stimulus tasks and the top module tb. Depends on sawpc_pkg and the block.

module tb;
	import sawpc_pkg::*;

	localparam int IDLE_PCT = 21;
	localparam int SETTLE_CYCLES = 4;
	localparam int WATCHDOG_LIMIT = 2000;
	localparam int RANDOM_SAMPLES = 900;
	localparam int PULSES_PER_PHASE = 20;
	localparam longint unsigned CAP_RAW = MAX_PULSE_SAMPLES_DEF;
	localparam int unsigned COUNT_CAP = (CAP_RAW > 65535) ? 65535 :
		((CAP_RAW < 1) ? 1 : int'(CAP_RAW));

	typedef struct packed {
		logic                         form_ok;
		logic [COUNT_W-1:0]           bad_index;
		logic [1:0]                   amp_status;
		logic signed [SAMPLE_W-1:0]   measured_min;
		logic signed [SAMPLE_W-1:0]   measured_max;
		logic                         width_ok;
		logic [COUNT_W-1:0]           measured_width;
		logic                         all_ok;
	} verdict_t;

	// Scoreboard: tracks the pulse in flight and queues the verdicts it predicts
	class pulse_verdict_model;
		logic signed [SAMPLE_W-1:0] low_target;
		logic signed [SAMPLE_W-1:0] high_target;
		logic [TOL_W-1:0]           tol;
		logic [COUNT_W-1:0]         want_width;
		logic signed [SAMPLE_W-1:0] run_min;
		logic signed [SAMPLE_W-1:0] run_max;
		logic signed [SAMPLE_W-1:0] prev_value;
		logic [COUNT_W-1:0]         count;
		logic [COUNT_W-1:0]         first_bad;
		bit                         rising;
		verdict_t                   pending_verdicts[$];
		int                         failures;

		function new();
			low_target = '0;
			high_target = '0;
			tol = '0;
			want_width = '0;
			failures = 0;
			clear_pulse();
		endfunction

		function void clear_pulse();
			run_min = '0;
			run_max = '0;
			prev_value = '0;
			count = '0;
			first_bad = '0;
			rising = 1'b1;
		endfunction

		function void write_reg(cfg_reg_t idx, logic [CFG_W-1:0] data);
			case (idx)
			REG_AMP_LOW_TARGET:  low_target = data;
			REG_AMP_HIGH_TARGET: high_target = data;
			REG_TOLERANCE:       tol = data[TOL_W-1:0];
			REG_EXPECTED_WIDTH:  want_width = data;
			default: ;
			endcase
		endfunction

		// Both window edges count as inside; int math keeps the edges from wrapping
		function bit in_window(logic signed [SAMPLE_W-1:0] value,
			logic signed [SAMPLE_W-1:0] target);
			int lo_edge;
			int hi_edge;
			lo_edge = int'(target) - int'(tol);
			hi_edge = int'(target) + int'(tol);
			return int'(value) >= lo_edge && int'(value) <= hi_edge;
		endfunction

		// Note one accepted sample transfer; a last sample queues a verdict
		function void take_sample(logic signed [SAMPLE_W-1:0] value, logic is_last);
			verdict_t v;
			if (count == 0) begin
				run_min = value;
				run_max = value;
			end else begin
				if (rising && prev_value >= value) begin
					rising = 1'b0;
					first_bad = count - 1'b1;
				end
				if (value < run_min) run_min = value;
				if (value > run_max) run_max = value;
			end
			prev_value = value;
			if (count < COUNT_CAP) count = count + 1'b1;
			if (!is_last) return;

			v.amp_status = AMP_NORMAL;
			if (!in_window(run_min, low_target)) v.amp_status |= AMP_MIN_OUT;
			if (!in_window(run_max, high_target)) v.amp_status |= AMP_MAX_OUT;
			v.width_ok = (count == want_width);
			v.form_ok = rising;
			v.bad_index = rising ? '0 : first_bad;
			v.measured_min = run_min;
			v.measured_max = run_max;
			v.measured_width = count;
			v.all_ok = rising && v.width_ok && v.amp_status == AMP_NORMAL;
			pending_verdicts.push_back(v);
			clear_pulse();
		endfunction

		static function string describe(verdict_t v);
			return $sformatf("form=%0d bad=%0d amp=%0d min=%0d max=%0d wok=%0d width=%0d all=%0d",
				v.form_ok, v.bad_index, v.amp_status, v.measured_min, v.measured_max,
				v.width_ok, v.measured_width, v.all_ok);
		endfunction

		// Check one verdict transfer against the oldest prediction
		function void compare_verdict(verdict_t got);
			verdict_t want;
			if (pending_verdicts.size() == 0) begin
				failures++;
				if (failures <= 10)
					$display("%0t: unexpected verdict: %s", $realtime, describe(got));
				return;
			end
			want = pending_verdicts.pop_front();
			if (got != want) begin
				failures++;
				if (failures <= 10) begin
					$display("%0t: verdict mismatch", $realtime);
					$display("  expected %s", describe(want));
					$display("  actual   %s", describe(got));
				end
			end
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_write_en = 1'b0;
	cfg_reg_t cfg_index = REG_AMP_LOW_TARGET;
	logic [CFG_W-1:0] cfg_data = '0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic signed [SAMPLE_W-1:0] sample = '0;
	logic last_sample = 1'b0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic form_ok;
	logic [COUNT_W-1:0] bad_index;
	logic [1:0] amp_status;
	logic signed [SAMPLE_W-1:0] measured_min;
	logic signed [SAMPLE_W-1:0] measured_max;
	logic width_ok;
	logic [COUNT_W-1:0] measured_width;
	logic all_ok;

	int in_idle_pct = IDLE_PCT;
	int out_idle_pct = IDLE_PCT;
	int samples_sent = 0;
	int quiet_cycles = 0;
	logic signed [SAMPLE_W-1:0] pulse_buf[$];
	pulse_verdict_model model = new();

	sawtooth_pulse_checker i_dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_write_en   (cfg_write_en),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data),
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.sample         (sample),
		.last_sample    (last_sample),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.form_ok        (form_ok),
		.bad_index      (bad_index),
		.amp_status     (amp_status),
		.measured_min   (measured_min),
		.measured_max   (measured_max),
		.width_ok       (width_ok),
		.measured_width (measured_width),
		.all_ok         (all_ok)
	);

	always #4 clk = ~clk;

	// Stall the verdict channel at random
	always @(negedge clk) begin
		out_stall <= (out_idle_pct != 0) && ($urandom_range(0, 99) < out_idle_pct);
	end

	// Observe transfers on both channels and guard against a hang
	always @(posedge clk) begin : monitor
		verdict_t got;
		bit moved;
		if (arst_n) begin
			moved = cfg_write_en;
			if (in_valid && !in_stall) begin
				model.take_sample(sample, last_sample);
				moved = 1'b1;
			end
			if (out_valid && !out_stall) begin
				got = '{form_ok, bad_index, amp_status, measured_min, measured_max,
					width_ok, measured_width, all_ok};
				model.compare_verdict(got);
				moved = 1'b1;
			end
			quiet_cycles = moved ? 0 : quiet_cycles + 1;
			if (quiet_cycles >= WATCHDOG_LIMIT) begin
				$display("CHECKS FAILED");
				$finish;
			end
		end
	end

	function automatic logic signed [SAMPLE_W-1:0] clip16(int value);
		if (value > 32767) return 16'sh7fff;
		if (value < -32768) return 16'sh8000;
		return value[SAMPLE_W-1:0];
	endfunction

	// Present one sample after a random hold-off; returns at a falling edge
	task automatic push_sample(input logic signed [SAMPLE_W-1:0] value, input logic is_last);
		while (in_idle_pct != 0 && $urandom_range(0, 99) < in_idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		sample <= value;
		last_sample <= is_last;
		do @(posedge clk); while (in_stall);
		samples_sent++;
		@(negedge clk);
	endtask

	task automatic send_pulse();
		foreach (pulse_buf[i]) push_sample(pulse_buf[i], i == pulse_buf.size() - 1);
	endtask

	// Drop valid and wait until every verdict has arrived and the pipe is empty
	task automatic settle();
		in_valid <= 1'b0;
		while (model.pending_verdicts.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic put_reg(input cfg_reg_t idx, input logic [CFG_W-1:0] data);
		cfg_write_en <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		model.write_reg(idx, data);
		@(negedge clk);
	endtask

	task automatic write_config(input logic signed [SAMPLE_W-1:0] lo,
		input logic signed [SAMPLE_W-1:0] hi, input logic [TOL_W-1:0] tol,
		input logic [COUNT_W-1:0] width);
		put_reg(REG_AMP_LOW_TARGET, lo);
		put_reg(REG_AMP_HIGH_TARGET, hi);
		// the spare top bit of the tolerance write is don't-care
		put_reg(REG_TOLERANCE, {1'($urandom), tol});
		put_reg(REG_EXPECTED_WIDTH, width);
		cfg_write_en <= 1'b0;
	endtask

	// Style 0 is the widest setting, style 1 the all-zero one, others random
	task automatic pick_config(input int style);
		int lo;
		int hi;
		logic [TOL_W-1:0] tol;
		logic [COUNT_W-1:0] width;
		case (style)
		0: begin
			lo = -32768;
			hi = 32767;
			tol = $urandom_range(0, 1) ? 15'h7fff : 15'h0000;
			width = $urandom_range(0, 1) ? 16'hffff : 16'h0000;
		end
		1: begin
			lo = 0;
			hi = 0;
			tol = '0;
			width = '0;
		end
		default: begin
			lo = int'($urandom_range(0, 65535)) - 32768;
			hi = $urandom_range(0, 1) ? lo + int'($urandom_range(0, 3000))
				: int'($urandom_range(0, 65535)) - 32768;
			tol = TOL_W'(($urandom_range(0, 3) == 0) ? $urandom_range(0, 32767)
				: $urandom_range(0, 300));
			width = COUNT_W'(($urandom_range(0, 7) == 0) ? $urandom_range(0, 65535)
				: $urandom_range(1, 12));
		end
		endcase
		write_config(clip16(lo), clip16(hi), tol, width);
	endtask

	// Build one pulse: mostly rising ramps, some with a flaw, some pure noise
	task automatic build_random_pulse();
		int n;
		int kind;
		int span;
		int start;
		int stop;
		int swap;
		int pos;
		pulse_buf.delete();
		n = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 40) : $urandom_range(1, 12);
		if (model.want_width >= 1 && model.want_width <= 40 && $urandom_range(0, 2) == 0)
			n = int'(model.want_width);
		kind = $urandom_range(0, 99);
		if (kind < 70) begin
			if ($urandom_range(0, 1)) begin
				span = int'(model.tol) + 3;
				start = int'(model.low_target) + int'($urandom_range(0, 2 * span)) - span;
				stop = int'(model.high_target) + int'($urandom_range(0, 2 * span)) - span;
			end else begin
				start = int'($urandom_range(0, 65535)) - 32768;
				stop = int'($urandom_range(0, 65535)) - 32768;
			end
			start = int'(clip16(start));
			stop = int'(clip16(stop));
			if (stop < start) begin
				swap = start;
				start = stop;
				stop = swap;
			end
			for (int i = 0; i < n; i++)
				pulse_buf.push_back(clip16((n == 1) ? start
					: start + (stop - start) * i / (n - 1)));
			// break the rise at one place
			if (kind >= 50 && n > 1) begin
				pos = $urandom_range(1, n - 1);
				pulse_buf[pos] = clip16(int'(pulse_buf[pos - 1]) - int'($urandom_range(0, 3)));
			end
		end else begin
			for (int i = 0; i < n; i++) pulse_buf.push_back(16'($urandom));
		end
	endtask

	initial begin
		int base;
		int phase;
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Directed pulses around a narrow window setting
		write_config(-100, 100, 10, 5);
		pulse_buf = '{-100, -50, 0, 50, 100};
		send_pulse();
		pulse_buf = '{-110, 0, 110};
		send_pulse();
		pulse_buf = '{7};
		send_pulse();
		pulse_buf = '{1, 2, 2, 3};
		send_pulse();
		pulse_buf = '{5, 4};
		send_pulse();
		pulse_buf = '{-32768, 32767};
		send_pulse();
		pulse_buf = '{32767, -32768};
		send_pulse();
		pulse_buf = '{-111, 100};
		send_pulse();
		pulse_buf = '{-100, 111};
		send_pulse();
		pulse_buf = '{-89, 90};
		send_pulse();

		// Random phases; the first one runs with no idling on either side
		base = samples_sent;
		phase = 0;
		while (samples_sent - base < RANDOM_SAMPLES) begin
			settle();
			in_idle_pct = (phase == 0) ? 0 : IDLE_PCT;
			out_idle_pct = (phase == 0) ? 0 : IDLE_PCT;
			pick_config((phase == 1) ? 0 : (phase == 2) ? 1 : $urandom_range(0, 5));
			for (int p = 0; p < PULSES_PER_PHASE; p++) begin
				build_random_pulse();
				send_pulse();
			end
			phase++;
		end

		settle();
		repeat (2 * SETTLE_CYCLES) @(posedge clk);
		if (model.failures == 0 && model.pending_verdicts.size() == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("CHECKS FAILED");
		end
		$finish;
	end

endmodule
